/* rtl/tce_pkg.sv */
// Shared types, codes and constants for the record-list ID extractor.
`default_nettype none

package tce_pkg;

   // Payload and result field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned KEY_W    = 16;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned POS_W    = 17;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned LIMIT_W  = 5;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAX_ENTRIES = 1'd0,
      CSR_TARGET_KEY  = 1'd1
   } csr_index_type;

   // Reset values and defaults
   localparam int unsigned      DEF_MAX_ENTRIES = 16;
   localparam logic [LIMIT_W-1:0] RST_MAX_ENTRIES = 5'd16;
   localparam logic [KEY_W-1:0]   RST_TARGET_KEY  = 16'd41;

   // Record decode constants
   localparam logic [LEN_W-1:0]   PAD_MASK     = 16'hFFFE;
   localparam logic [VALUE_W-1:0] ID_ALL_ONES  = 32'hFFFF_FFFF;
   localparam int unsigned        INFO_MORE_BIT = 7;
   localparam logic [6:0]         INFO_LEN_MASK = 7'h7F;

   // Result codes
   typedef enum logic {
      KIND_ENTRY  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_LEN = 2'd1,
      ST_END      = 2'd2
   } status_type;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PH_SEARCHING = 3'b001,
      PH_LISTING   = 3'b010,
      PH_DONE      = 3'b100
   } phase_type;

endpackage

`default_nettype wire

/* rtl/tce_if.sv */
// Channel interfaces: payload bytes in, list results out, register writes.
`default_nettype none

interface tce_req_if
   import tce_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic              is_last;

   modport source (output valid, payload_byte, is_last, input ready);
   modport sink   (input valid, payload_byte, is_last, output ready);
endinterface

interface tce_rsp_if
   import tce_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [INDEX_W-1:0]  entry_index;
   logic [VALUE_W-1:0]  entry_value;
   logic                finished;
   logic [STATUS_W-1:0] status;

   modport source (output valid, kind, entry_index, entry_value, finished, status,
                   input ready);
   modport sink   (input valid, kind, entry_index, entry_value, finished, status,
                   output ready);
endinterface

interface tce_csr_if
   import tce_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/tlv_config_id_list_extractor_unit.sv */
// A byte's result (if any) is registered when the byte is accepted and shows in the next cycle.
// One payload byte per cycle unless stalled; record parsing is a combinational state update.
// The only stall comes from the result register when a word waits on rsp_chan.ready.
// Reset (synchronous, active high): phase searching, counters cleared, no result
// pending, max_entries 16 and target_key 41.
`default_nettype none

module tlv_config_id_list_extractor_unit
   import tce_pkg::*;
#(
   parameter int unsigned MAX_ENTRIES = DEF_MAX_ENTRIES
) (
   input  wire         clock,
   input  wire         reset,
   tce_req_if.sink     req_chan,
   tce_rsp_if.source   rsp_chan,
   tce_csr_if.sink     csr_chan
);

   localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // Configuration registers
   logic [LIMIT_W-1:0] max_entries_ff;
   logic [KEY_W-1:0]   target_key_ff;

   // Parser state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [BYTE_W-1:0]  vb_ff [1:4];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic                fin_ff, fin_in;
   status_type          st_ff, st_in;
   logic                emit;

   logic              req_fire;
   logic [BYTE_W-1:0] b;
   logic              last;
   logic              active;
   logic [LEN_W-1:0]  pad_len;
   logic [POS_W-1:0]  end_pos;
   logic              at_end;
   logic [BYTE_W-1:0] info;
   logic              info_more;
   logic              id_found;
   logic [VALUE_W-1:0] id_val;
   logic [CNT_W-1:0]  cnt_inc;
   logic [LIM_W-1:0]  limit_now;
   logic              term;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign b              = req_chan.payload_byte;
   assign last           = req_chan.is_last;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= RST_MAX_ENTRIES;
         target_key_ff  <= RST_TARGET_KEY;
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_MAX_ENTRIES: max_entries_ff <= csr_chan.data[LIMIT_W-1:0];
            CSR_TARGET_KEY:  target_key_ff  <= csr_chan.data[KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Header fields, merged with the current byte
   always_comb begin
      key_in = key_ff;
      len_in = len_ff;
      if (pos_ff == POS_W'(0)) begin
         key_in = {{(KEY_W-BYTE_W){1'b0}}, b};
      end else if (pos_ff == POS_W'(1)) begin
         key_in = {b, key_ff[BYTE_W-1:0]};
      end else if (pos_ff == POS_W'(2)) begin
         len_in = {{(LEN_W-BYTE_W){1'b0}}, b};
      end else if (pos_ff == POS_W'(3)) begin
         len_in = {b, len_ff[BYTE_W-1:0]};
      end
   end

   // Record end: the padded length wraps at 16 bits
   assign pad_len = (len_in + LEN_W'(1)) & PAD_MASK;
   assign end_pos = POS_W'(3) + {1'b0, pad_len};
   assign at_end  = (pos_ff == end_pos);
   assign active  = (phase_ff == PH_SEARCHING) || (phase_ff == PH_LISTING);

   // ID decode; the final value byte of a record is always the current byte
   assign info      = (len_in == LEN_W'(2)) ? b : vb_ff[1];
   assign info_more = info[INFO_MORE_BIT];
   always_comb begin
      id_found = 1'b0;
      id_val   = '0;
      if (len_in == LEN_W'(2)) begin
         id_found = 1'b1;
         id_val   = {{(VALUE_W-BYTE_W){1'b0}}, b};
      end else if (len_in == LEN_W'(4) && info_more
                   && (info[6:0] & INFO_LEN_MASK) == 7'd2) begin
         id_found = 1'b1;
         id_val   = {{(VALUE_W-2*BYTE_W){1'b0}}, vb_ff[2], b};
      end else if (len_in == LEN_W'(6) && info_more
                   && (info[6:0] & INFO_LEN_MASK) == 7'd4) begin
         id_found = 1'b1;
         id_val   = {vb_ff[2], vb_ff[3], vb_ff[4], b};
      end
   end

   // Entry limit
   assign cnt_inc = cnt_ff + CNT_W'(1);
   always_comb begin
      if (max_entries_ff == '0 || LIM_W'(max_entries_ff) > LIM_W'(MAX_ENTRIES)) begin
         limit_now = LIM_W'(MAX_ENTRIES);
      end else begin
         limit_now = LIM_W'(max_entries_ff);
      end
   end

   // Parser step for one byte
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      emit     = 1'b0;
      kind_in  = KIND_STATUS;
      idx_in   = '0;
      val_in   = '0;
      fin_in   = 1'b0;
      st_in    = ST_OK;
      term     = 1'b0;
      if (!active) begin
         if (last) begin
            phase_in = PH_SEARCHING;
            pos_in   = '0;
            cnt_in   = '0;
         end
      end else begin
         if (phase_ff == PH_LISTING && pos_ff == POS_W'(1) && key_in != target_key_ff) begin
            // a different key follows the list
            emit   = 1'b1;
            fin_in = 1'b1;
         end else if (at_end) begin
            if (key_in == target_key_ff) begin
               phase_in = PH_LISTING;
               if (len_in == '0) begin
                  emit   = 1'b1;
                  fin_in = 1'b1;
                  st_in  = ST_ZERO_LEN;
               end else begin
                  if (id_found) begin
                     emit    = 1'b1;
                     kind_in = KIND_ENTRY;
                     val_in  = id_val;
                     if (id_val == ID_ALL_ONES) begin
                        term = 1'b1;
                     end else begin
                        idx_in = INDEX_W'(cnt_ff);
                        cnt_in = cnt_inc;
                        term   = (id_val == '0) || (LIM_W'(cnt_inc) >= limit_now);
                     end
                  end
                  if (term) begin
                     fin_in = 1'b1;
                  end else if (last) begin
                     emit   = 1'b1;
                     fin_in = 1'b1;
                     st_in  = ST_END;
                  end
               end
            end else begin
               if (len_in == '0) begin
                  emit   = 1'b1;
                  fin_in = 1'b1;
                  st_in  = ST_ZERO_LEN;
               end else if (last) begin
                  emit   = 1'b1;
                  fin_in = 1'b1;
                  st_in  = ST_END;
               end
            end
            pos_in = '0;
         end else if (last) begin
            emit   = 1'b1;
            fin_in = 1'b1;
            st_in  = ST_END;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
         // end of parsing: restart on the final byte, else wait for it
         if (fin_in) begin
            if (last) begin
               phase_in = PH_SEARCHING;
               pos_in   = '0;
               cnt_in   = '0;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCHING;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Header and value bytes, always written before they are read
   always_ff @(posedge clock) begin
      if (req_fire && active) begin
         key_ff <= key_in;
         len_ff <= len_in;
         if (pos_ff == POS_W'(5)) vb_ff[1] <= b;
         if (pos_ff == POS_W'(6)) vb_ff[2] <= b;
         if (pos_ff == POS_W'(7)) vb_ff[3] <= b;
         if (pos_ff == POS_W'(8)) vb_ff[4] <= b;
      end
   end

   // Result register
   assign rsp_valid_in = req_fire ? emit : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         kind_ff <= kind_in;
         idx_ff  <= idx_in;
         val_ff  <= val_in;
         fin_ff  <= fin_in;
         st_ff   <= st_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.kind        = kind_ff;
   assign rsp_chan.entry_index = idx_ff;
   assign rsp_chan.entry_value = val_ff;
   assign rsp_chan.finished    = fin_ff;
   assign rsp_chan.status      = st_ff;

endmodule

`default_nettype wire

/* rtl/tce_checker.sv */
// Port-level checks for the extractor, bound to the top level.
`default_nettype none

module tce_checker
   import tce_pkg::*;
(
   input wire                clock,
   input wire                reset,
   input wire                rsp_valid,
   input wire                rsp_ready,
   input wire                rsp_kind,
   input wire [INDEX_W-1:0]  rsp_entry_index,
   input wire [VALUE_W-1:0]  rsp_entry_value,
   input wire                rsp_finished,
   input wire [STATUS_W-1:0] rsp_status
);

   // A pending word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped before it was taken");

   // A status-only word always ends parsing and carries no ID
   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |->
         rsp_finished && rsp_entry_index == '0 && rsp_entry_value == '0)
      else $error("status word with entry data or not finished");

   // Status is OK while the list is still open
   a_open_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_finished |-> rsp_status == ST_OK)
      else $error("non-OK status on an unfinished word");

   // The all-ones ID closes the list at index 0 with OK status
   a_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ENTRY && rsp_entry_value == ID_ALL_ONES |->
         rsp_entry_index == '0 && rsp_finished && rsp_status == ST_OK)
      else $error("all-ones ID not reported as list end");

endmodule

bind tlv_config_id_list_extractor_unit tce_checker u_tce_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_entry_index (rsp_chan.entry_index),
   .rsp_entry_value (rsp_chan.entry_value),
   .rsp_finished    (rsp_chan.finished),
   .rsp_status      (rsp_chan.status)
);

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the record-list ID extractor: directed table, then random payloads.
`timescale 1ns / 1ps

module tb;
   import tce_pkg::*;

   localparam int ENTRY_CAP   = 16;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_BYTES = 290;
   localparam int TAIL_CYCLES = 4;
   localparam int LONG_HOLD   = 120;

   // Phase styles
   localparam int RUN_PLAIN = 0;
   localparam int RUN_HOLD  = 1;
   localparam int RUN_PAUSE = 2;
   localparam int RUN_QUIET = 3;

   // Where a table row gets its expectation
   localparam logic BY_MODEL = 1'b0;
   localparam logic TYPED    = 1'b1;

   typedef struct packed {
      kind_type   kind;
      logic [3:0] idx;
      logic [31:0] value;
      logic       fin;
      status_type st;
   } id_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      logic       emit;
      id_result_type res;
   } dir_row_type;

   localparam id_result_type NO_RES = '{KIND_STATUS, 4'd0, 32'd0, 1'b0, ST_OK};

   logic clock;
   logic reset;

   tce_req_if req_bus ();
   tce_rsp_if rsp_bus ();
   tce_csr_if csr_bus ();

   tlv_config_id_list_extractor_unit #(.MAX_ENTRIES(ENTRY_CAP)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state and register copies
   phase_type   ph;
   logic [16:0] rec_pos;
   logic [15:0] rec_key;
   logic [15:0] rec_len;
   logic [7:0]  val_b [0:5];
   logic [8:0]  ent_cnt;
   logic [4:0]  cfg_max;
   logic [15:0] cfg_key;

   id_result_type pending_ids [$];
   logic [7:0] pl [$];
   logic [7:0] rec_val [0:5];

   bit src_gaps;
   bit src_gaps_now;
   bit rx_gaps;
   bit hold_req;
   int n_errors;
   int n_bytes;
   int n_payloads;
   int n_checked;
   int n_settings;
   int cycle_count;

   // Directed table, reset config (limit 16, key 0x0029)
   dir_row_type dir_tab [0:35] = '{
      // key 0xFFFF, length 0xFFFF: pads to zero, header only, skipped
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, TYPED,    1'b0, NO_RES},
      // target record, one-byte ID
      '{8'h29, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h02, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hAA, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h05, 1'b0, TYPED, 1'b1, '{KIND_ENTRY, 4'd0, 32'h5, 1'b0, ST_OK}},
      // different key closes the list on its second byte
      '{8'h07, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, TYPED, 1'b1, '{KIND_STATUS, 4'd0, 32'h0, 1'b1, ST_OK}},
      // trailing byte ignored, its last flag restarts
      '{8'h55, 1'b1, TYPED,    1'b0, NO_RES},
      // zero-length target record
      '{8'h29, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b1, TYPED, 1'b1, '{KIND_STATUS, 4'd0, 32'h0, 1'b1, ST_ZERO_LEN}},
      // two-byte ID form
      '{8'h29, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h04, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h82, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h12, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h34, 1'b0, BY_MODEL, 1'b0, NO_RES},
      // four-byte all-ones ID ends the list at index 0
      '{8'h29, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h06, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h00, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'h84, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b0, BY_MODEL, 1'b0, NO_RES},
      '{8'hFF, 1'b1, TYPED, 1'b1, '{KIND_ENTRY, 4'd0, 32'hFFFF_FFFF, 1'b1, ST_OK}},
      // stream ends inside a record header
      '{8'h29, 1'b1, TYPED, 1'b1, '{KIND_STATUS, 4'd0, 32'h0, 1'b1, ST_END}}
   };

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Back to the start of a payload
   task automatic clear_parse();
      ph = PH_SEARCHING;
      rec_pos = '0;
      rec_key = '0;
      rec_len = '0;
      foreach (val_b[i]) val_b[i] = '0;
      ent_cnt = '0;
   endtask

   // Predict the word (if any) caused by one payload byte
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             output logic emit, output id_result_type r);
      logic [16:0] pos;
      logic [16:0] rec_end;
      logic [15:0] padded;
      logic [4:0]  limit;
      logic [31:0] id;
      logic        found;
      logic        ones;
      logic        term;
      logic        fin;
      pos = rec_pos;
      emit = 1'b0;
      fin = 1'b0;
      term = 1'b0;
      found = 1'b0;
      ones = 1'b0;
      id = '0;
      r = NO_RES;
      limit = (cfg_max == 0 || cfg_max > ENTRY_CAP) ? 5'(ENTRY_CAP) : cfg_max;
      if (ph == PH_SEARCHING || ph == PH_LISTING) begin
         // capture header and the first value bytes
         if (pos == 0) rec_key = {8'h00, b};
         else if (pos == 1) rec_key[15:8] = b;
         else if (pos == 2) rec_len = {8'h00, b};
         else if (pos == 3) rec_len[15:8] = b;
         else if (pos < 10) val_b[int'(pos) - 4] = b;
         padded = (rec_len + 16'd1) & PAD_MASK;
         rec_end = 17'd3 + {1'b0, padded};

         if (ph == PH_LISTING && pos == 1 && rec_key != cfg_key) begin
            emit = 1'b1;
            fin = 1'b1;
         end else if (pos >= 3 && pos == rec_end) begin
            if (rec_key == cfg_key) begin
               ph = PH_LISTING;
               if (rec_len == 0) begin
                  emit = 1'b1;
                  fin = 1'b1;
                  r.st = ST_ZERO_LEN;
               end else begin
                  // ID forms: 1 byte, or more bit with 2 or 4 bytes
                  if (rec_len == 2) begin
                     id = {24'h0, val_b[1]};
                     found = 1'b1;
                  end else if (rec_len == 4 && val_b[1][INFO_MORE_BIT] &&
                               (val_b[1][6:0] & INFO_LEN_MASK) == 7'd2) begin
                     id = {16'h0, val_b[2], val_b[3]};
                     found = 1'b1;
                  end else if (rec_len == 6 && val_b[1][INFO_MORE_BIT] &&
                               (val_b[1][6:0] & INFO_LEN_MASK) == 7'd4) begin
                     id = {val_b[2], val_b[3], val_b[4], val_b[5]};
                     found = 1'b1;
                     ones = (id == ID_ALL_ONES);
                  end
                  if (found) begin
                     emit = 1'b1;
                     r.kind = KIND_ENTRY;
                     r.value = id;
                     if (ones) begin
                        r.idx = '0;
                        term = 1'b1;
                     end else begin
                        r.idx = ent_cnt[3:0];
                        ent_cnt = ent_cnt + 9'd1;
                        term = (id == 0) || (ent_cnt >= {4'd0, limit});
                     end
                  end
                  if (term) begin
                     fin = 1'b1;
                  end else if (last) begin
                     emit = 1'b1;
                     fin = 1'b1;
                     r.st = ST_END;
                  end
               end
            end else begin
               if (rec_len == 0) begin
                  emit = 1'b1;
                  fin = 1'b1;
                  r.st = ST_ZERO_LEN;
               end else if (last) begin
                  emit = 1'b1;
                  fin = 1'b1;
                  r.st = ST_END;
               end
            end
            rec_pos = '0;
         end else if (last) begin
            emit = 1'b1;
            fin = 1'b1;
            r.st = ST_END;
         end else begin
            rec_pos = pos + 17'd1;
         end

         if (fin) begin
            if (last) clear_parse();
            else ph = PH_DONE;
         end
         r.fin = fin;
      end else if (last) begin
         clear_parse();
      end
   endtask

   // Offer one byte, wait for the handshake, then record the expected word
   task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                            input logic t_emit, input id_result_type t_res);
      logic          emit;
      id_result_type r;
      req_bus.valid <= 1'b1;
      req_bus.payload_byte <= b;
      req_bus.is_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      parse_byte(b, last, emit, r);
      if (typed) begin
         emit = t_emit;
         r = t_res;
      end
      if (emit) pending_ids.push_back(r);
      n_bytes++;
      if (src_gaps_now && $urandom_range(0, 6) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Write both registers back to back, keeping valid high between words
   task automatic write_regs(input logic [15:0] max_d, input logic [15:0] key_d);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_MAX_ENTRIES;
      csr_bus.data <= max_d;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_max = max_d[4:0];
      csr_bus.index <= CSR_TARGET_KEY;
      csr_bus.data <= key_d;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_key = key_d;
      csr_bus.valid <= 1'b0;
      n_settings++;
   endtask

   // Drain all expected words, then let the pipeline settle
   task automatic settle();
      while (pending_ids.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] other_key();
      logic [15:0] k;
      k = 16'($urandom);
      if (k == cfg_key) k = ~k;
      return k;
   endfunction

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      if (r == 2) return 16'($urandom_range(8, 40));
      return 16'($urandom_range(1, 7));
   endfunction

   // Header plus padded value; first six value bytes come from rec_val
   task automatic push_record(input logic [15:0] key, input logic [15:0] len);
      logic [15:0] padded;
      int i;
      padded = (len + 16'd1) & PAD_MASK;
      pl.push_back(key[7:0]);
      pl.push_back(key[15:8]);
      pl.push_back(len[7:0]);
      pl.push_back(len[15:8]);
      for (i = 0; i < int'(padded); i++)
         pl.push_back(i < 6 ? rec_val[i] : 8'($urandom));
   endtask

   // One target record: mostly valid ID forms, some zero IDs and malformed ones
   task automatic push_id_record(input logic dense);
      int sel;
      logic [15:0] len;
      foreach (rec_val[i]) rec_val[i] = 8'($urandom);
      sel = dense ? 0 : $urandom_range(0, 15);
      len = 16'd2;
      if (sel < 6) begin
         if (dense && rec_val[1] == 0) rec_val[1] = 8'h01;
      end else if (sel < 10) begin
         len = 16'd4;
         rec_val[1] = 8'h82;
      end else if (sel < 13) begin
         len = 16'd6;
         rec_val[1] = 8'h84;
         if (sel == 12) for (int i = 2; i < 6; i++) rec_val[i] = 8'hFF;
      end else if (sel == 13) begin
         rec_val[1] = 8'h00;
      end else if (sel == 14) begin
         len = 16'($urandom_range(1, 8));
         if ($urandom_range(0, 1)) rec_val[1] = {1'b1, 7'($urandom_range(0, 6))};
      end else begin
         len = 16'd0;
      end
      push_record(cfg_key, len);
   endtask

   // Build one payload: skipped records, a list, maybe a foreign record,
   // trailing junk, or an early cut; a few are pure noise
   task automatic build_payload(input logic dense);
      int cut;
      pl.delete();
      if (!dense && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) pl.push_back(8'($urandom));
      end else begin
         repeat (dense ? 0 : $urandom_range(0, 2)) begin
            foreach (rec_val[i]) rec_val[i] = 8'($urandom);
            push_record(other_key(), pick_len());
         end
         repeat (dense ? ENTRY_CAP : $urandom_range(1, 8)) push_id_record(dense);
         if (!dense && $urandom_range(0, 1)) begin
            foreach (rec_val[i]) rec_val[i] = 8'($urandom);
            push_record(other_key(), 16'($urandom_range(1, 4)));
         end
         if (!dense && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 5)) pl.push_back(8'($urandom));
         if (!dense && $urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, pl.size());
            while (pl.size() > cut) void'(pl.pop_back());
         end
      end
   endtask

   task automatic send_payload(input logic dense);
      int i;
      build_payload(dense);
      n_payloads++;
      src_gaps_now = src_gaps && ($urandom_range(0, 3) != 0);
      for (i = 0; i < pl.size(); i++)
         send_byte(pl[i], i == pl.size() - 1, BY_MODEL, 1'b0, NO_RES);
   endtask

   // One register setting followed by random payloads
   task automatic run_phase(input logic [15:0] max_d, input logic [15:0] key_d,
                            input int mode);
      int start;
      bit paused;
      paused = 1'b0;
      settle();
      write_regs(max_d, key_d);
      if (mode == RUN_QUIET) begin
         src_gaps = 1'b0;
         rx_gaps = 1'b0;
      end
      start = n_bytes;
      if (mode == RUN_HOLD) begin
         // long sink stall while a dense list keeps arriving
         hold_req = 1'b1;
         send_payload(1'b1);
      end
      while (n_bytes - start < PHASE_BYTES) begin
         if (mode == RUN_PAUSE && !paused && n_bytes - start >= PHASE_BYTES / 2) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            while (pending_ids.size() != 0) @(posedge clock);
         end
         send_payload(1'b0);
      end
      req_bus.valid <= 1'b0;
   endtask

   // Result sink: random stall bursts, plus one long hold on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = $urandom_range(0, 5);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         n_errors++;
      end
   endtask

   // Compare each accepted word with the oldest expectation
   always @(posedge clock) begin
      id_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_ids.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual kind %0d index %0d value 0x%0h",
                     $time, rsp_bus.kind, rsp_bus.entry_index, rsp_bus.entry_value);
            n_errors++;
         end else begin
            want = pending_ids.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
            check_field("entry_index", 32'(want.idx), 32'(rsp_bus.entry_index));
            check_field("entry_value", want.value, rsp_bus.entry_value);
            check_field("finished", 32'(want.fin), 32'(rsp_bus.finished));
            check_field("status", 32'(want.st), 32'(rsp_bus.status));
            n_checked++;
         end
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.payload_byte = '0;
      req_bus.is_last = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_MAX_ENTRIES;
      csr_bus.data = '0;
      src_gaps = 1'b1;
      src_gaps_now = 1'b1;
      rx_gaps = 1'b1;
      hold_req = 1'b0;
      n_errors = 0;
      n_bytes = 0;
      n_payloads = 0;
      n_checked = 0;
      n_settings = 0;
      cfg_max = RST_MAX_ENTRIES;
      cfg_key = RST_TARGET_KEY;
      clear_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset settings
      foreach (dir_tab[i])
         send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed,
                   dir_tab[i].emit, dir_tab[i].res);
      req_bus.valid <= 1'b0;

      // random payloads over several settings; upper data bits of the limit are junk
      run_phase({11'($urandom), 5'd1}, 16'h0000, RUN_PLAIN);
      run_phase({11'($urandom), 5'd16}, 16'hFFFF, RUN_PLAIN);
      run_phase({11'($urandom), 5'd0}, 16'($urandom), RUN_PLAIN);
      run_phase({11'($urandom), 5'd31}, RST_TARGET_KEY, RUN_HOLD);
      run_phase({11'($urandom), 5'($urandom_range(1, 16))}, 16'($urandom), RUN_PAUSE);
      run_phase({11'($urandom), 5'd3}, 16'($urandom), RUN_QUIET);
      settle();

      $display("Covered %0d payload bytes in %0d payloads over %0d register settings",
               n_bytes, n_payloads, n_settings + 1);
      $display("Compared %0d result words, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0 && pending_ids.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
